// ===== hdl/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// bse_pkg
// Types, codes and checksum helpers shared by the bech32 stream encoder.
// ----------------------------------------------------------------------------
package bse_pkg;

   typedef enum logic [1:0] {
      KIND_PREFIX = 2'd0,
      KIND_VALUE  = 2'd1,
      KIND_BYTE   = 2'd2,
      KIND_END    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_PREFIX = 2'd0,
      PH_DATA   = 2'd1,
      PH_ERROR  = 2'd2
   } phase_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ECHO,
      S_OPEN,
      S_REPLAY,
      S_SEP,
      S_GROUP,
      S_BYTE,
      S_PAD,
      S_CKSTEP,
      S_CKOUT,
      S_ERR
   } state_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [6:0] character;
      logic       last;
      logic       error;
   } rsp_type;

   localparam logic [29:0] GEN0 = 30'h3b6a57b2;
   localparam logic [29:0] GEN1 = 30'h26508e6d;
   localparam logic [29:0] GEN2 = 30'h1ea119fa;
   localparam logic [29:0] GEN3 = 30'h3d4233dd;
   localparam logic [29:0] GEN4 = 30'h2a1462b3;

   localparam logic [29:0] CHK_INIT  = 30'd1;
   localparam logic [29:0] CHK_FINAL = 30'd1;

   localparam logic [6:0] CHAR_SEP   = 7'h31;
   localparam logic [7:0] CHAR_MIN   = 8'd33;
   localparam logic [7:0] CHAR_MAX   = 8'd126;
   localparam logic [7:0] CHAR_UP_LO = 8'h41;
   localparam logic [7:0] CHAR_UP_HI = 8'h5a;

   localparam logic [6:0] CHARSET [32] = '{
      7'h71, 7'h70, 7'h7a, 7'h72, 7'h79, 7'h39, 7'h78, 7'h38,
      7'h67, 7'h66, 7'h32, 7'h74, 7'h76, 7'h64, 7'h77, 7'h30,
      7'h73, 7'h33, 7'h6a, 7'h6e, 7'h35, 7'h34, 7'h6b, 7'h68,
      7'h63, 7'h65, 7'h36, 7'h6d, 7'h75, 7'h61, 7'h37, 7'h6c
   };

   function automatic logic [29:0] poly_step(input logic [29:0] c);
      logic [4:0]  top;
      logic [29:0] r;
      top = c[29:25];
      r   = {c[24:0], 5'b0};
      if (top[0]) r = r ^ GEN0;
      if (top[1]) r = r ^ GEN1;
      if (top[2]) r = r ^ GEN2;
      if (top[3]) r = r ^ GEN3;
      if (top[4]) r = r ^ GEN4;
      return r;
   endfunction

   function automatic logic [6:0] charset_char(input logic [4:0] g);
      return CHARSET[g];
   endfunction

endpackage

// ===== hdl/bech32_stream_encoder_core.sv =====
// ----------------------------------------------------------------------------
// bech32_stream_encoder_core
// Streaming bech32 encoder: prefix check and echo, 8-to-5 regrouping,
// separator, data characters and six-character checksum.
// ----------------------------------------------------------------------------
// One item is taken at a time and its characters leave through a single
// output register, one per cycle when the result side does not stall. A
// rejected item, or any non-end item after a rejection, is dropped with no
// result. The end item runs a pad step, six checksum steps and six checksum
// characters. The first data or end item of a message also replays the
// stored prefix from the prefix memory, one read port so one entry a cycle.
// An end item after a rejected message yields one result with error and
// last set.
// ----------------------------------------------------------------------------
module bech32_stream_encoder_core
   import bse_pkg::*;
#(
   parameter int MAX_PREFIX = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   localparam int AW = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;
   localparam int CW = $clog2(MAX_PREFIX + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PREFIX);

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [29:0] cs_ff, cs_in;
   logic [CW-1:0] pcount_ff, pcount_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [2:0]  ck_ff, ck_in;
   logic [11:0] buf_ff, buf_in;
   logic [3:0]  bcnt_ff, bcnt_in;
   kind_type    kind_ff, kind_in;
   logic [7:0]  value_ff, value_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_item_ff, rsp_item_in;

   logic [6:0]    pfx_mem [MAX_PREFIX];
   logic [6:0]    rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          mem_we;

   logic acc;
   logic out_free;
   logic emit;
   logic prefix_bad;
   logic value_bad;

   assign acc      = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset || (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign prefix_bad = (phase_ff != PH_PREFIX) || (req_item.value < CHAR_MIN) ||
                       (req_item.value > CHAR_MAX) ||
                       ((req_item.value >= CHAR_UP_LO) && (req_item.value <= CHAR_UP_HI)) ||
                       (pcount_ff >= MAX_CNT);
   assign value_bad  = (req_item.value[7:5] != 3'd0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (acc) begin
               if (phase_ff == PH_ERROR) begin
                  state_in = (req_item.kind == KIND_END) ? S_ERR : S_IDLE;
               end else begin
                  unique case (req_item.kind)
                     KIND_PREFIX: state_in = prefix_bad ? S_IDLE : S_ECHO;
                     KIND_VALUE: begin
                        if (value_bad) state_in = S_IDLE;
                        else state_in = (phase_ff == PH_PREFIX) ? S_OPEN : S_GROUP;
                     end
                     KIND_BYTE:  state_in = (phase_ff == PH_PREFIX) ? S_OPEN : S_BYTE;
                     KIND_END:   state_in = (phase_ff == PH_PREFIX) ? S_OPEN : S_PAD;
                  endcase
               end
            end
         end
         S_ECHO, S_GROUP, S_ERR: begin
            if (out_free) state_in = S_IDLE;
         end
         S_OPEN: state_in = S_REPLAY;
         S_REPLAY: begin
            if (idx_ff == pcount_ff) state_in = S_SEP;
         end
         S_SEP: begin
            if (out_free) begin
               unique case (kind_ff)
                  KIND_VALUE:  state_in = S_GROUP;
                  KIND_BYTE:   state_in = S_BYTE;
                  KIND_END:    state_in = S_PAD;
                  KIND_PREFIX: state_in = S_IDLE;
               endcase
            end
         end
         S_BYTE: begin
            if (out_free && (bcnt_ff < 4'd10)) state_in = S_IDLE;
         end
         S_PAD: begin
            if ((bcnt_ff == 4'd0) || out_free) state_in = S_CKSTEP;
         end
         S_CKSTEP: begin
            if (ck_ff == 3'd5) state_in = S_CKOUT;
         end
         S_CKOUT: begin
            if (out_free && (ck_ff == 3'd5)) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic [2:0]  sh;
      logic [11:0] shifted;
      logic [4:0]  g;
      logic [4:0]  pad;
      logic [CW-1:0] idx_nx;

      phase_in    = phase_ff;
      cs_in       = cs_ff;
      pcount_in   = pcount_ff;
      idx_in      = idx_ff;
      ck_in       = ck_ff;
      buf_in      = buf_ff;
      bcnt_in     = bcnt_ff;
      kind_in     = kind_ff;
      value_in    = value_ff;
      rsp_item_in = rsp_item_ff;
      emit        = 1'b0;
      mem_we      = 1'b0;
      rd_addr     = idx_ff[AW-1:0];
      sh          = 3'(bcnt_ff - 4'd5);
      shifted     = buf_ff >> sh;
      g           = shifted[4:0];
      pad         = buf_ff[4:0] << (3'd5 - bcnt_ff[2:0]);
      idx_nx      = idx_ff + 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (acc) begin
               kind_in  = req_item.kind;
               value_in = req_item.value;
               if (phase_ff != PH_ERROR) begin
                  unique case (req_item.kind)
                     KIND_PREFIX: begin
                        if (prefix_bad) begin
                           phase_in = PH_ERROR;
                        end else begin
                           mem_we    = 1'b1;
                           pcount_in = pcount_ff + 1'b1;
                           cs_in     = poly_step(cs_ff) ^ {27'd0, req_item.value[7:5]};
                        end
                     end
                     KIND_VALUE: begin
                        if (value_bad) phase_in = PH_ERROR;
                     end
                     KIND_BYTE: begin
                        buf_in  = {buf_ff[3:0], req_item.value};
                        bcnt_in = bcnt_ff + 4'd8;
                     end
                     KIND_END: ;
                  endcase
               end
            end
         end
         S_ECHO: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_item_in = '{character: value_ff[6:0], last: 1'b0, error: 1'b0};
            end
         end
         S_OPEN: begin
            cs_in   = poly_step(cs_ff);
            idx_in  = '0;
            rd_addr = '0;
         end
         S_REPLAY: begin
            if (idx_ff != pcount_ff) begin
               cs_in   = poly_step(cs_ff) ^ {25'd0, rd_data_ff[4:0]};
               idx_in  = idx_nx;
               rd_addr = idx_nx[AW-1:0];
            end
         end
         S_SEP: begin
            if (out_free) begin
               emit        = 1'b1;
               phase_in    = PH_DATA;
               rsp_item_in = '{character: CHAR_SEP, last: 1'b0, error: 1'b0};
            end
         end
         S_GROUP: begin
            if (out_free) begin
               emit        = 1'b1;
               cs_in       = poly_step(cs_ff) ^ {25'd0, value_ff[4:0]};
               rsp_item_in = '{character: charset_char(value_ff[4:0]), last: 1'b0,
                               error: 1'b0};
            end
         end
         S_BYTE: begin
            if (out_free) begin
               emit        = 1'b1;
               cs_in       = poly_step(cs_ff) ^ {25'd0, g};
               bcnt_in     = bcnt_ff - 4'd5;
               rsp_item_in = '{character: charset_char(g), last: 1'b0, error: 1'b0};
            end
         end
         S_PAD: begin
            ck_in = 3'd0;
            if ((bcnt_ff != 4'd0) && out_free) begin
               emit        = 1'b1;
               cs_in       = poly_step(cs_ff) ^ {25'd0, pad};
               bcnt_in     = 4'd0;
               rsp_item_in = '{character: charset_char(pad), last: 1'b0, error: 1'b0};
            end
         end
         S_CKSTEP: begin
            if (ck_ff == 3'd5) begin
               cs_in = poly_step(cs_ff) ^ CHK_FINAL;
               ck_in = 3'd0;
            end else begin
               cs_in = poly_step(cs_ff);
               ck_in = ck_ff + 3'd1;
            end
         end
         S_CKOUT: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_item_in = '{character: charset_char(cs_ff[29:25]),
                               last: (ck_ff == 3'd5), error: 1'b0};
               cs_in       = {cs_ff[24:0], 5'b0};
               ck_in       = ck_ff + 3'd1;
               if (ck_ff == 3'd5) begin
                  cs_in     = CHK_INIT;
                  pcount_in = '0;
                  phase_in  = PH_PREFIX;
                  buf_in    = '0;
                  bcnt_in   = '0;
                  ck_in     = 3'd0;
               end
            end
         end
         S_ERR: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_item_in = '{character: 7'd0, last: 1'b1, error: 1'b1};
               cs_in       = CHK_INIT;
               pcount_in   = '0;
               phase_in    = PH_PREFIX;
               buf_in      = '0;
               bcnt_in     = '0;
            end
         end
         default: ;
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_PREFIX;
         cs_ff        <= CHK_INIT;
         pcount_ff    <= '0;
         idx_ff       <= '0;
         ck_ff        <= 3'd0;
         buf_ff       <= '0;
         bcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cs_ff        <= cs_in;
         pcount_ff    <= pcount_in;
         idx_ff       <= idx_in;
         ck_ff        <= ck_in;
         buf_ff       <= buf_in;
         bcnt_ff      <= bcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      value_ff    <= value_in;
      rsp_item_ff <= rsp_item_in;
   end

   // prefix memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pfx_mem[pcount_ff[AW-1:0]] <= req_item.value[6:0];
      end
      rd_data_ff <= pfx_mem[rd_addr];
   end

`ifndef SYNTHESIS
   a_final_resets: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CKOUT && out_free && ck_ff == 3'd5) |=>
      (cs_ff == CHK_INIT && phase_ff == PH_PREFIX && pcount_ff == '0 && bcnt_ff == 4'd0))
      else $error("state not cleared after final checksum item");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.error) |-> (rsp_item.last && rsp_item.character == 7'd0))
      else $error("error item not a bare last item");

   a_pcount_range: assert property (@(posedge clock) disable iff (reset)
      pcount_ff <= MAX_CNT)
      else $error("prefix count beyond limit");

   a_idle_bits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (bcnt_ff < 4'd5))
      else $error("full group left pending at idle");

   a_replay_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPLAY) |-> (idx_ff <= pcount_ff))
      else $error("replay index past prefix count");
`endif

endmodule

// ===== verif/tb_bech32_stream_encoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_bech32_stream_encoder_core
// Self-checking bench for the streaming bech32 encoder. Messages of prefix
// characters, five-bit values, regrouped bytes and end items are sent mostly
// under random idle and stall. An in-bench encoder model predicts every output
// character, and each result item is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_bech32_stream_encoder_core;
   import bse_pkg::*;

   localparam int HRP_MAX = 16;
   localparam logic [7:0] PRINT_LO = 8'd33;
   localparam logic [7:0] PRINT_HI = 8'd126;
   localparam logic [7:0] UPPER_A  = 8'h41;
   localparam logic [7:0] UPPER_Z  = 8'h5a;
   localparam logic [6:0] SEP_CHAR = 7'h31;
   localparam logic [149:0] GEN_POLY = {
      30'h2a1462b3, 30'h3d4233dd, 30'h1ea119fa, 30'h26508e6d, 30'h3b6a57b2
   };
   localparam logic [255:0] B32_SET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

   // flaws injected into a random message
   localparam int FLAW_NONE     = 0;
   localparam int FLAW_BAD_CHAR = 1;
   localparam int FLAW_WIDE     = 2;
   localparam int FLAW_LATE_HRP = 3;
   localparam int FLAW_OVERFLOW = 4;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   int idle_pct = 7;
   int stall_pct = 7;
   int items_sent = 0;
   int mismatch_count = 0;

   rsp_type expected_chars[$];

   // encoder model state
   logic [29:0] enc_sum;
   logic [6:0]  hrp_mem [HRP_MAX];
   int          hrp_len;
   phase_type   enc_phase;
   logic [11:0] pend_bits;
   int          pend_cnt;

   bech32_stream_encoder_core #(.MAX_PREFIX(HRP_MAX)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #10 clock = ~clock;

   function automatic logic [29:0] cksum_shift(input logic [29:0] c);
      logic [29:0] r;
      r = {c[24:0], 5'd0};
      for (int i = 0; i < 5; i++) begin
         if (c[25 + i]) r = r ^ GEN_POLY[30 * i +: 30];
      end
      return r;
   endfunction

   function automatic logic [6:0] b32_char(input logic [4:0] g);
      return B32_SET[8 * (31 - g) +: 7];
   endfunction

   task automatic clear_encoder();
      enc_sum = 30'd1;
      hrp_len = 0;
      enc_phase = PH_PREFIX;
      pend_bits = '0;
      pend_cnt = 0;
   endtask

   task automatic expect_char(input logic [6:0] ch, input logic lst, input logic er);
      rsp_type r;
      r.character = ch;
      r.last = lst;
      r.error = er;
      expected_chars.push_back(r);
   endtask

   task automatic put_group(input logic [4:0] g);
      enc_sum = cksum_shift(enc_sum) ^ {25'd0, g};
      expect_char(b32_char(g), 1'b0, 1'b0);
   endtask

   // first data or end item: separator step, low bits of the prefix, '1'
   task automatic open_data_part();
      if (enc_phase == PH_PREFIX) begin
         enc_sum = cksum_shift(enc_sum);
         for (int i = 0; i < hrp_len; i++)
            enc_sum = cksum_shift(enc_sum) ^ {25'd0, hrp_mem[i][4:0]};
         enc_phase = PH_DATA;
         expect_char(SEP_CHAR, 1'b0, 1'b0);
      end
   endtask

   task automatic encode_item(input req_type it);
      logic [7:0]  v;
      logic [11:0] padded;
      v = it.value;
      if (it.kind == KIND_END) begin
         if (enc_phase == PH_ERROR) begin
            expect_char(7'd0, 1'b1, 1'b1);
         end else begin
            open_data_part();
            if (pend_cnt != 0) begin
               padded = pend_bits << (5 - pend_cnt);
               put_group(padded[4:0]);
            end
            for (int i = 0; i < 6; i++) enc_sum = cksum_shift(enc_sum);
            enc_sum = enc_sum ^ 30'd1;
            for (int i = 0; i < 6; i++)
               expect_char(b32_char(enc_sum[(5 - i) * 5 +: 5]), i == 5, 1'b0);
         end
         clear_encoder();
      end else if (enc_phase != PH_ERROR) begin
         case (it.kind)
            KIND_PREFIX: begin
               if (enc_phase != PH_PREFIX || v < PRINT_LO || v > PRINT_HI ||
                   (v >= UPPER_A && v <= UPPER_Z) || hrp_len >= HRP_MAX) begin
                  enc_phase = PH_ERROR;
               end else begin
                  hrp_mem[hrp_len] = v[6:0];
                  hrp_len++;
                  enc_sum = cksum_shift(enc_sum) ^ {27'd0, v[7:5]};
                  expect_char(v[6:0], 1'b0, 1'b0);
               end
            end
            KIND_VALUE: begin
               if (v > 8'd31) begin
                  enc_phase = PH_ERROR;
               end else begin
                  open_data_part();
                  put_group(v[4:0]);
               end
            end
            default: begin
               open_data_part();
               pend_bits = {pend_bits[3:0], v};
               pend_cnt += 8;
               while (pend_cnt >= 5) begin
                  pend_cnt -= 5;
                  padded = pend_bits >> pend_cnt;
                  put_group(padded[4:0]);
               end
            end
         endcase
      end
   endtask

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_item(input kind_type k, input logic [7:0] v);
      req_type it;
      it.kind = k;
      it.value = v;
      encode_item(it);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain_all();
      int n;
      n = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0 && n < 20000) begin
         @(posedge clock);
         n++;
      end
      if (expected_chars.size() != 0)
         flag_mismatch("results never arrived, count", expected_chars.size(), 0);
      expected_chars.delete();
   endtask

   function automatic logic [7:0] good_char();
      logic [7:0] c;
      c = 8'($urandom_range(PRINT_HI, PRINT_LO));
      while (c >= UPPER_A && c <= UPPER_Z) c = 8'($urandom_range(PRINT_HI, PRINT_LO));
      return c;
   endfunction

   function automatic logic [7:0] bad_char();
      case ($urandom_range(2))
         0: return 8'($urandom_range(PRINT_LO - 1, 0));
         1: return 8'($urandom_range(255, PRINT_HI + 1));
         default: return 8'($urandom_range(UPPER_Z, UPPER_A));
      endcase
   endfunction

   task automatic send_data_item();
      if ($urandom_range(1)) send_item(KIND_VALUE, 8'($urandom_range(31)));
      else send_item(KIND_BYTE, 8'($urandom_range(255)));
   endtask

   task automatic send_message(input int hrp_n, input int data_n, input int flaw);
      int n;
      n = (flaw == FLAW_OVERFLOW) ? HRP_MAX + 1 : hrp_n;
      for (int i = 0; i < n; i++) send_item(KIND_PREFIX, good_char());
      if (flaw == FLAW_BAD_CHAR) send_item(KIND_PREFIX, bad_char());
      for (int i = 0; i < data_n; i++) send_data_item();
      if (flaw == FLAW_WIDE) send_item(KIND_VALUE, 8'($urandom_range(255, 32)));
      if (flaw == FLAW_LATE_HRP) begin
         send_data_item();
         send_item(KIND_PREFIX, good_char());
      end
      if (flaw != FLAW_NONE) begin
         n = $urandom_range(3);
         for (int i = 0; i < n; i++)
            send_item(kind_type'($urandom_range(2)), 8'($urandom_range(255)));
      end
      send_item(KIND_END, 8'($urandom_range(255)));
   endtask

   task automatic test_empty_message();
      send_item(KIND_END, 8'hff);
   endtask

   task automatic test_basic_message();
      send_item(KIND_PREFIX, 8'h61);
      send_item(KIND_PREFIX, PRINT_LO);
      send_item(KIND_PREFIX, PRINT_HI);
      send_item(KIND_VALUE, 8'd0);
      send_item(KIND_BYTE, 8'hff);
      send_item(KIND_VALUE, 8'd31);
      send_item(KIND_BYTE, 8'h00);
      send_item(KIND_END, 8'h00);
   endtask

   task automatic test_bad_prefix_chars();
      send_item(KIND_PREFIX, PRINT_LO - 1);
      send_item(KIND_END, 8'h00);
      send_item(KIND_PREFIX, UPPER_A);
      send_item(KIND_END, 8'h00);
      send_item(KIND_PREFIX, PRINT_HI + 1);
      send_item(KIND_BYTE, 8'ha5);
      send_item(KIND_END, 8'h00);
      send_item(KIND_PREFIX, UPPER_Z);
      send_item(KIND_END, 8'h00);
   endtask

   task automatic test_wide_value();
      send_item(KIND_VALUE, 8'd32);
      send_item(KIND_END, 8'h00);
   endtask

   task automatic test_prefix_after_data();
      send_item(KIND_PREFIX, 8'h61);
      send_item(KIND_VALUE, 8'd1);
      send_item(KIND_PREFIX, 8'h62);
      send_item(KIND_END, 8'h00);
   endtask

   task automatic test_prefix_overflow();
      send_message(0, 0, FLAW_OVERFLOW);
   endtask

   task automatic test_random_messages(input int target);
      int stop;
      int sel;
      int hn;
      int dn;
      stop = items_sent + target;
      while (items_sent < stop) begin
         sel = $urandom_range(99);
         hn = ($urandom_range(7) == 0) ? HRP_MAX : $urandom_range(5);
         dn = $urandom_range(10);
         if (sel < 80) send_message(hn, dn, FLAW_NONE);
         else if (sel < 94) send_message(hn, dn, $urandom_range(FLAW_OVERFLOW, FLAW_BAD_CHAR));
         else send_item(kind_type'($urandom_range(3)), 8'($urandom_range(255)));
      end
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            flag_mismatch("result with nothing expected", int'(rsp_item), 0);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_item.character !== want.character)
               flag_mismatch("character", int'(rsp_item.character), int'(want.character));
            if (rsp_item.last !== want.last)
               flag_mismatch("last", int'(rsp_item.last), int'(want.last));
            if (rsp_item.error !== want.error)
               flag_mismatch("error", int'(rsp_item.error), int'(want.error));
         end
      end
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   initial begin
      clear_encoder();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_message();
      test_basic_message();
      test_bad_prefix_chars();
      test_wide_value();
      test_prefix_after_data();
      test_prefix_overflow();
      drain_all();
      test_random_messages(170);
      drain_all();
      idle_pct = 0;
      stall_pct = 0;
      test_random_messages(120);
      idle_pct = 7;
      stall_pct = 7;
      test_random_messages(70);
      drain_all();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
